FILE: design/wrw_pkg.sv
// ----------------------------------------------------------------------------
// wrw_pkg
// Shared types and constants for the weighted random walk particle block.
// ----------------------------------------------------------------------------
package wrw_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_WEIGHT_UP    = 3'd0;
    localparam logic [2:0] REG_WEIGHT_DOWN  = 3'd1;
    localparam logic [2:0] REG_WEIGHT_LEFT  = 3'd2;
    localparam logic [2:0] REG_WEIGHT_RIGHT = 3'd3;
    localparam logic [2:0] REG_GOAL_COLUMN  = 3'd4;
    localparam logic [2:0] REG_HALF_WIDTH   = 3'd5;

    // reset values of the configuration registers
    localparam logic [7:0] RST_WEIGHT_UP    = 8'd15;
    localparam logic [7:0] RST_WEIGHT_DOWN  = 8'd15;
    localparam logic [7:0] RST_WEIGHT_LEFT  = 8'd5;
    localparam logic [7:0] RST_WEIGHT_RIGHT = 8'd65;
    localparam logic [4:0] RST_GOAL_COLUMN  = 5'd10;
    localparam logic [4:0] RST_HALF_WIDTH   = 5'd5;

    // direction codes
    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_UP    = 3'd1;
    localparam logic [2:0] DIR_DOWN  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    localparam int RAND_W   = 32;
    localparam int SUM_W    = 10;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_RESOLVE
    } wrw_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } wrw_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } wrw_status_t;

endpackage

FILE: design/weighted_random_walk_particles.sv
// ----------------------------------------------------------------------------
// weighted_random_walk_particles
// Biased lattice random walk of a particle table with absorbing goal column.
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one beat per step: a particle index and a 32-bit random word.
//   m_* returns one result beat per accepted beat, in order.
//   cfg_we/cfg_addr/cfg_wdata write the six registers (weights, goal column,
//   half width); write only while no beat is in flight.
// sequence:
//   a beat is taken in idle, the remainder of the random word by the weight
//   sum is formed in the one-bit-per-cycle remainder loop, then the move is
//   resolved and the result registered at commit; the next beat is taken
//   only after that commit, so beats are not overlapped.
// reset:
//   all particles return to the origin, none arrived, the walking count is
//   NUM_PARTICLES and registers take their defaults; no clearing pass.
// stall:
//   a result waits in the output register; the next beat is taken and worked
//   on meanwhile, and holds before commit until the register is free.
// ----------------------------------------------------------------------------
module weighted_random_walk_particles
    import wrw_pkg::*;
#(
    parameter int NUM_PARTICLES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_addr,
    input  logic [7:0]             cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // particle[3:0], rand_value[35:4], zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_particle[3:0], direction[6:4], new_x[11:7], new_y[17:12],
    // was_reset[18], arrived_now[19], already_arrived[20], all_arrived[21],
    // weight_error[22], zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    wrw_cmd_t    cmd;
    wrw_status_t status;

    wrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wrw_datapath #(
        .NUM_PARTICLES (NUM_PARTICLES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: design/wrw_ctrl.sv
// ----------------------------------------------------------------------------
// wrw_ctrl
// Sequencer: accepts a beat, runs the bit-serial modulo, then commits.
// ----------------------------------------------------------------------------
module wrw_ctrl
    import wrw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  wrw_status_t status,
    output wrw_cmd_t    cmd
);

    wrw_state_t state_reg;
    wrw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            ST_RESOLVE:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/wrw_datapath.sv
// ----------------------------------------------------------------------------
// wrw_datapath
// Configuration, particle table, serial remainder unit and result register.
// ----------------------------------------------------------------------------
module wrw_datapath
    import wrw_pkg::*;
#(
    parameter int NUM_PARTICLES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_addr,
    input  logic [7:0]             cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  wrw_cmd_t               cmd,
    output wrw_status_t            status
);

    localparam int DEPTH = (NUM_PARTICLES < 16) ? NUM_PARTICLES : 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(NUM_PARTICLES + 1);

    // configuration
    logic [7:0] w_up_reg, w_down_reg, w_left_reg, w_right_reg;
    logic [4:0] goal_reg, half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_up_reg    <= RST_WEIGHT_UP;
            w_down_reg  <= RST_WEIGHT_DOWN;
            w_left_reg  <= RST_WEIGHT_LEFT;
            w_right_reg <= RST_WEIGHT_RIGHT;
            goal_reg    <= RST_GOAL_COLUMN;
            half_reg    <= RST_HALF_WIDTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_WEIGHT_UP:    w_up_reg    <= cfg_wdata;
                REG_WEIGHT_DOWN:  w_down_reg  <= cfg_wdata;
                REG_WEIGHT_LEFT:  w_left_reg  <= cfg_wdata;
                REG_WEIGHT_RIGHT: w_right_reg <= cfg_wdata;
                REG_GOAL_COLUMN:  goal_reg    <= cfg_wdata[4:0];
                REG_HALF_WIDTH:   half_reg    <= cfg_wdata[4:0];
                default:          ;
            endcase
        end
    end

    // running weight sums
    logic [SUM_W-1:0] s1, s2, s3, s4;

    always_comb
    begin
        s1 = SUM_W'(w_up_reg);
        s2 = s1 + SUM_W'(w_down_reg);
        s3 = s2 + SUM_W'(w_left_reg);
        s4 = s3 + SUM_W'(w_right_reg);
    end

    // beat capture and restoring remainder, one bit per cycle
    logic [3:0]        particle_reg;
    logic [RAND_W-1:0] shift_reg;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [4:0]        bit_cnt_reg;
    logic [SUM_W:0]    trial, diff;

    always_comb
    begin
        trial = {rem_reg, shift_reg[RAND_W-1]};
        diff  = trial - {1'b0, s4};
        if (trial >= {1'b0, s4})
        begin
            rem_next = diff[SUM_W-1:0];
        end
        else
        begin
            rem_next = trial[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            particle_reg <= s_tdata[3:0];
            shift_reg    <= s_tdata[35:4];
            rem_reg      <= '0;
            bit_cnt_reg  <= '0;
        end
        else if (cmd.step)
        begin
            shift_reg   <= {shift_reg[RAND_W-2:0], 1'b0};
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_reg + 5'd1;
        end
    end

    assign status.div_last = cmd.step && (bit_cnt_reg == 5'd31);

    // particle table
    logic [4:0]      pos_x_reg [DEPTH];
    logic [5:0]      pos_y_reg [DEPTH];
    logic [DEPTH-1:0] arrived_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [IDX_W-1:0] idx;
    logic             p_valid;
    logic [4:0]       cur_x, nx;
    logic [5:0]       cur_y, ny;
    logic [SUM_W-1:0] r;
    logic [2:0]       dir;
    logic [6:0]       tx, ty, ay;
    logic             in_strip, moved, was_reset, arrived_now, already, werr;

    assign idx     = particle_reg[IDX_W-1:0];
    assign p_valid = (32'(particle_reg) < NUM_PARTICLES);
    assign cur_x   = pos_x_reg[idx];
    assign cur_y   = pos_y_reg[idx];
    assign r       = rem_reg + SUM_W'(1);

    always_comb
    begin
        tx = {2'b00, cur_x};
        ty = {cur_y[5], cur_y};
        if (s1 >= r)
        begin
            dir = DIR_UP;
            ty  = {cur_y[5], cur_y} + 7'd1;
        end
        else if (s2 >= r)
        begin
            dir = DIR_DOWN;
            ty  = {cur_y[5], cur_y} - 7'd1;
        end
        else if (s3 >= r)
        begin
            dir = DIR_LEFT;
            tx  = {2'b00, cur_x} - 7'd1;
        end
        else
        begin
            dir = DIR_RIGHT;
            tx  = {2'b00, cur_x} + 7'd1;
        end
        ay       = ty[6] ? (~ty + 7'd1) : ty;
        // x must stay within 0..31
        in_strip = !tx[6] && !tx[5] && (ay < {2'b00, half_reg});

        already     = 1'b0;
        werr        = 1'b0;
        moved       = 1'b0;
        was_reset   = 1'b0;
        arrived_now = 1'b0;
        nx          = '0;
        ny          = '0;
        if (p_valid)
        begin
            nx = cur_x;
            ny = cur_y;
            if (arrived_reg[idx])
            begin
                already = 1'b1;
            end
            else if (s4 == '0)
            begin
                werr = 1'b1;
            end
            else
            begin
                moved = 1'b1;
                if (!in_strip)
                begin
                    nx        = '0;
                    ny        = '0;
                    was_reset = 1'b1;
                end
                else
                begin
                    nx          = tx[4:0];
                    ny          = ty[5:0];
                    arrived_now = (dir == DIR_RIGHT) && (tx[4:0] == goal_reg);
                end
            end
        end
        if (!moved)
        begin
            dir = DIR_NONE;
        end
        count_next = count_reg;
        if (arrived_now && (count_reg != '0))
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                pos_x_reg[i] <= '0;
                pos_y_reg[i] <= '0;
            end
            arrived_reg <= '0;
            count_reg   <= CNT_W'(NUM_PARTICLES);
        end
        else if (cmd.commit)
        begin
            if (moved)
            begin
                pos_x_reg[idx] <= nx;
                pos_y_reg[idx] <= ny;
            end
            if (arrived_now)
            begin
                arrived_reg[idx] <= 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // result register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_tdata_reg <= {1'b0, werr, (count_next == '0), already, arrived_now,
                            was_reset, ny, nx, dir, particle_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // walking count only ever drops
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg <= $past(count_reg))
        else $error("walking count increased");

    // remainder ends below the divisor
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (s4 != '0) |-> rem_reg < s4)
        else $error("remainder not reduced");

    // an absorbed particle is marked right after its result
    a_arrival_marked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && arrived_now |=> arrived_reg[$past(idx)])
        else $error("arrival not recorded");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted random walk particle block.
// A queue of steps feeds a stream driver. Each accepted beat updates a
// shadow particle table and queues the result that the block should return.
// A monitor compares the result beats field by field, in order. Directed
// steps cover the edges of the strip, absorption and zero weights. Random
// phases follow under several register settings and back-pressure patterns.
// A final phase walks every particle into the goal column.
// ----------------------------------------------------------------------------
module tb_top
    import wrw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PARTICLE_COUNT = 16;
    localparam int X_LIMIT        = 31;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [31:0] rand_value;
        logic [3:0]  particle;
    } step_req_t;

    typedef struct packed {
        logic       weight_error;
        logic       all_arrived;
        logic       already_arrived;
        logic       arrived_now;
        logic       was_reset;
        logic [5:0] new_y;
        logic [4:0] new_x;
        logic [2:0] direction;
        logic [3:0] particle;
    } walk_result_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [2:0]             cfg_addr  = '0;
    logic [7:0]             cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // shadow copy of the particle table and the registers
    int          track_x [PARTICLE_COUNT];
    int          track_y [PARTICLE_COUNT];
    bit          absorbed [PARTICLE_COUNT];
    int          walkers_left = PARTICLE_COUNT;
    bit [7:0]    wt_up    = RST_WEIGHT_UP;
    bit [7:0]    wt_down  = RST_WEIGHT_DOWN;
    bit [7:0]    wt_left  = RST_WEIGHT_LEFT;
    bit [7:0]    wt_right = RST_WEIGHT_RIGHT;
    bit [4:0]    goal_x   = RST_GOAL_COLUMN;
    bit [4:0]    strip_half = RST_HALF_WIDTH;

    step_req_t    pending_steps [$];
    walk_result_t expected_results [$];

    int send_idle_pct = 10;
    int recv_idle_pct = 63;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    weighted_random_walk_particles #(
        .NUM_PARTICLES (PARTICLE_COUNT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic walk_result_t advance_particle(input step_req_t req);
        walk_result_t res;
        int x, y, tx, ty, ay;
        int unsigned s1, s2, s3, s4, pick;
        res = '0;
        res.particle = req.particle;
        x = track_x[req.particle];
        y = track_y[req.particle];
        if (absorbed[req.particle])
        begin
            res.already_arrived = 1'b1;
        end
        else
        begin
            s1 = wt_up;
            s2 = s1 + wt_down;
            s3 = s2 + wt_left;
            s4 = s3 + wt_right;
            if (s4 == 0)
            begin
                res.weight_error = 1'b1;
            end
            else
            begin
                pick = req.rand_value % s4 + 1;
                tx = x;
                ty = y;
                if (pick <= s1)
                begin
                    res.direction = DIR_UP;
                    ty = y + 1;
                end
                else if (pick <= s2)
                begin
                    res.direction = DIR_DOWN;
                    ty = y - 1;
                end
                else if (pick <= s3)
                begin
                    res.direction = DIR_LEFT;
                    tx = x - 1;
                end
                else
                begin
                    res.direction = DIR_RIGHT;
                    tx = x + 1;
                end
                ay = (ty < 0) ? -ty : ty;
                if (tx < 0 || tx > X_LIMIT || ay >= int'(strip_half))
                begin
                    // left the strip: back to the origin
                    x = 0;
                    y = 0;
                    res.was_reset = 1'b1;
                end
                else
                begin
                    x = tx;
                    y = ty;
                    if (res.direction == DIR_RIGHT && x == int'(goal_x))
                    begin
                        res.arrived_now = 1'b1;
                        absorbed[req.particle] = 1'b1;
                        if (walkers_left > 0)
                            walkers_left--;
                    end
                end
                track_x[req.particle] = x;
                track_y[req.particle] = y;
            end
        end
        res.new_x = 5'(x);
        res.new_y = 6'(y);
        res.all_arrived = (walkers_left == 0);
        return res;
    endfunction

    // sender: one beat in flight, prediction taken at acceptance
    always @(posedge clk or negedge rst_n)
    begin : step_driver
        step_req_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                expected_results.push_back(advance_particle(step_req_t'(s_tdata[35:0])));
            if (pending_steps.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req = pending_steps.pop_front();
                s_tdata  <= {{(IN_TDATA_W - $bits(step_req_t)){1'b0}}, req};
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver: random back-pressure plus long holds on request
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        walk_result_t want;
        walk_result_t got;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = walk_result_t'(m_tdata[$bits(walk_result_t)-1:0]);
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no step outstanding: %h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("out_particle", want.particle, got.particle);
                    check_field("direction", want.direction, got.direction);
                    check_field("new_x", want.new_x, got.new_x);
                    check_field("new_y", $signed(want.new_y), $signed(got.new_y));
                    check_field("was_reset", want.was_reset, got.was_reset);
                    check_field("arrived_now", want.arrived_now, got.arrived_now);
                    check_field("already_arrived", want.already_arrived,
                                got.already_arrived);
                    check_field("all_arrived", want.all_arrived, got.all_arrived);
                    check_field("weight_error", want.weight_error, got.weight_error);
                end
            end
            if (hold_requests != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_step(input logic [3:0] idx, input logic [31:0] rnd);
        step_req_t req;
        req.particle   = idx;
        req.rand_value = rnd;
        pending_steps.push_back(req);
    endtask

    // random steps, mostly on particles still walking when the phase starts
    task automatic queue_random_steps(input int count);
        int walkers [$];
        for (int p = 0; p < PARTICLE_COUNT; p++)
            if (!absorbed[p])
                walkers.push_back(p);
        repeat (count)
        begin
            if (walkers.size() == 0 || $urandom_range(9) == 0)
                queue_step(4'($urandom_range(PARTICLE_COUNT - 1)), $urandom());
            else
                queue_step(4'(walkers[$urandom_range(walkers.size() - 1)]), $urandom());
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_steps.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_WEIGHT_UP:    wt_up      = val;
            REG_WEIGHT_DOWN:  wt_down    = val;
            REG_WEIGHT_LEFT:  wt_left    = val;
            REG_WEIGHT_RIGHT: wt_right   = val;
            REG_GOAL_COLUMN:  goal_x     = val[4:0];
            REG_HALF_WIDTH:   strip_half = val[4:0];
            default: ;
        endcase
    endtask

    task automatic set_walk_config(input logic [7:0] w_up, input logic [7:0] w_down,
                                   input logic [7:0] w_left, input logic [7:0] w_right,
                                   input logic [7:0] goal, input logic [7:0] half);
        write_reg(REG_WEIGHT_UP, w_up);
        write_reg(REG_WEIGHT_DOWN, w_down);
        write_reg(REG_WEIGHT_LEFT, w_left);
        write_reg(REG_WEIGHT_RIGHT, w_right);
        write_reg(REG_GOAL_COLUMN, goal);
        write_reg(REG_HALF_WIDTH, half);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int steps_needed;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults: words 0/15/30/35 pick up/down/left/right
        queue_step(4'd0, 32'd30);
        repeat (5) queue_step(4'd1, 32'd0);
        repeat (5) queue_step(4'd2, 32'd15);
        repeat (10) queue_step(4'd15, 32'd35);
        queue_step(4'd15, 32'hFFFF_FFFF);
        queue_step(4'd3, 32'hFFFF_FFFF);
        wait_drained();

        // zero weights; an absorbed particle reports that first
        set_walk_config(8'd0, 8'd0, 8'd0, 8'd0, RST_GOAL_COLUMN, RST_HALF_WIDTH);
        queue_step(4'd4, 32'h8000_0001);
        queue_step(4'd15, 32'd0);
        wait_drained();

        set_walk_config(RST_WEIGHT_UP, RST_WEIGHT_DOWN, RST_WEIGHT_LEFT,
                        RST_WEIGHT_RIGHT, RST_GOAL_COLUMN, RST_HALF_WIDTH);
        queue_random_steps(100);
        wait_drained();

        set_walk_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd31, 8'd31);
        queue_random_steps(60);
        wait_drained();

        send_idle_pct = 63;
        recv_idle_pct = 10;
        set_walk_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(12, 31)), 8'($urandom_range(1, 31)));
        queue_random_steps(100);
        hold_requests++;
        wait_drained();

        // goal column 0 is never reached; half width 1 sends any y != 0 home.
        // upper data bits set to check they are dropped
        set_walk_config(8'd0, 8'd0, 8'd1, 8'd200, 8'hE0, 8'hA1);
        queue_random_steps(60);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_walk_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(1, 31)), 8'($urandom_range(1, 31)));
        queue_random_steps(150);
        hold_requests++;
        wait_drained();

        // right steps only, goal at x = 1: walk every particle into it
        set_walk_config(8'd0, 8'd0, 8'd0, 8'd255, 8'd1, 8'd31);
        for (int p = 0; p < PARTICLE_COUNT; p++)
        begin
            if (!absorbed[p])
            begin
                steps_needed = (track_x[p] == 0) ? 1 : X_LIMIT + 2 - track_x[p];
                repeat (steps_needed) queue_step(4'(p), $urandom());
            end
        end
        repeat (4) queue_step(4'($urandom_range(PARTICLE_COUNT - 1)), $urandom());
        wait_drained();

        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
